>>> rtl/pdcr_pkg.sv
`timescale 1ns / 1ps

package pdcr_pkg;

  localparam int unsigned OffW = 20;
  localparam int unsigned MaxRes = 8;
  localparam int unsigned CntW = 4;
  localparam int unsigned AddrW = 4;

  typedef struct packed {
    logic [31:0]     raw_sample;
    logic [2:0]      source_channel;
    logic [OffW-1:0] frame_offset;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        dest_channel;
    logic signed [31:0] sample_value;
    logic              accumulate;
    logic [OffW-1:0]   dest_offset;
    logic              last;
  } out_item_t;

  typedef enum logic [1:0] {
    REG_SAMPLE_WIDTH = 2'd0,
    REG_LAYOUT_MODE  = 2'd1,
    REG_WRITE_MODE   = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    SW_8U  = 2'd0,
    SW_16  = 2'd1,
    SW_24  = 2'd2,
    SW_32  = 2'd3
  } sample_width_e;

  typedef enum logic [3:0] {
    LM_PASS       = 4'd0,
    LM_MONO       = 4'd1,
    LM_M_STEREO   = 4'd2,
    LM_M_QUAD     = 4'd3,
    LM_S_QUAD     = 4'd4,
    LM_M_51       = 4'd5,
    LM_S_51       = 4'd6,
    LM_M_71       = 4'd7,
    LM_S_71       = 4'd8,
    LM_Q_71       = 4'd9,
    LM_51_71      = 4'd10,
    LM_51_STEREO  = 4'd11,
    LM_71_STEREO  = 4'd12,
    LM_Q_STEREO   = 4'd13
  } layout_e;

  typedef enum logic [2:0] {
    G_UNITY  = 3'd0,
    G_CENTRE = 3'd1,
    G_SURR   = 3'd2,
    G_QFRONT = 3'd3,
    G_QBACK  = 3'd4
  } gain_e;

  typedef struct packed {
    logic [CntW-1:0]         count;
    logic [MaxRes-1:0][2:0]  ch;
    logic [MaxRes-1:0]       mute;
    gain_e                   gain;
  } route_t;

  function automatic logic [15:0] gain_value(gain_e g);
    logic [15:0] r;
    case (g)
      G_UNITY:  r = 16'd32768;
      G_CENTRE: r = 16'd22938;
      G_SURR:   r = 16'd7864;
      G_QFRONT: r = 16'd29491;
      G_QBACK:  r = 16'd3277;
      default:  r = 16'd32768;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] normalize(logic [1:0] sw, logic [31:0] raw);
    logic [31:0] u;
    case (sample_width_e'(sw))
      SW_8U:   u = {~raw[7], raw[6:0], 24'd0};
      SW_16:   u = {raw[15:0], 16'd0};
      SW_24:   u = {raw[23:0], 8'd0};
      SW_32:   u = raw;
      default: u = raw;
    endcase
    return signed'(u);
  endfunction

  function automatic route_t route(logic [3:0] lm, logic [2:0] c);
    route_t r;
    r.count = '0;
    r.ch = '0;
    r.mute = '0;
    r.gain = G_UNITY;
    case (layout_e'(lm))
      LM_PASS: begin
        r.count = 4'd1; r.ch[0] = c;
      end
      LM_MONO: begin
        r.count = 4'd1; r.ch[0] = 3'd0;
      end
      LM_M_STEREO: begin
        r.count = 4'd2; r.ch[0] = 3'd0; r.ch[1] = 3'd1;
      end
      LM_M_QUAD: begin
        r.count = 4'd4;
        r.ch[0] = 3'd0; r.ch[1] = 3'd1; r.ch[2] = 3'd2; r.ch[3] = 3'd3;
      end
      LM_S_QUAD: begin
        if (c == 3'd0) begin
          r.count = 4'd2; r.ch[0] = 3'd0; r.ch[1] = 3'd2;
        end else if (c == 3'd1) begin
          r.count = 4'd2; r.ch[0] = 3'd1; r.ch[1] = 3'd3;
        end
      end
      LM_M_51: begin
        r.count = 4'd6;
        r.ch[0] = 3'd0; r.ch[1] = 3'd1; r.ch[2] = 3'd2;
        r.ch[3] = 3'd3; r.ch[4] = 3'd4; r.ch[5] = 3'd5;
      end
      LM_S_51: begin
        if (c == 3'd0) begin
          r.count = 4'd4;
          r.ch[0] = 3'd0; r.ch[1] = 3'd4; r.ch[2] = 3'd2; r.ch[3] = 3'd3;
          r.mute = 8'b0000_1100;
        end else if (c == 3'd1) begin
          r.count = 4'd2; r.ch[0] = 3'd1; r.ch[1] = 3'd5;
        end
      end
      LM_M_71: begin
        r.count = 4'd8;
        r.ch[0] = 3'd2; r.ch[1] = 3'd0; r.ch[2] = 3'd1; r.ch[3] = 3'd3;
        r.ch[4] = 3'd4; r.ch[5] = 3'd5; r.ch[6] = 3'd6; r.ch[7] = 3'd7;
        r.mute = 8'b1111_1110;
      end
      LM_S_71: begin
        if (c == 3'd0) begin
          r.count = 4'd7;
          r.ch[0] = 3'd0; r.ch[1] = 3'd2; r.ch[2] = 3'd3; r.ch[3] = 3'd4;
          r.ch[4] = 3'd5; r.ch[5] = 3'd6; r.ch[6] = 3'd7;
          r.mute = 8'b0111_1110;
        end else if (c == 3'd1) begin
          r.count = 4'd1; r.ch[0] = 3'd1;
        end
      end
      LM_Q_71: begin
        if (c == 3'd0) begin
          r.count = 4'd5;
          r.ch[0] = 3'd0; r.ch[1] = 3'd2; r.ch[2] = 3'd3; r.ch[3] = 3'd6;
          r.ch[4] = 3'd7;
          r.mute = 8'b0001_1110;
        end else if (c == 3'd1) begin
          r.count = 4'd1; r.ch[0] = 3'd1;
        end else if (c == 3'd2) begin
          r.count = 4'd1; r.ch[0] = 3'd4;
        end else if (c == 3'd3) begin
          r.count = 4'd1; r.ch[0] = 3'd5;
        end
      end
      LM_51_71: begin
        if (c == 3'd0) begin
          r.count = 4'd3;
          r.ch[0] = 3'd0; r.ch[1] = 3'd6; r.ch[2] = 3'd7;
          r.mute = 8'b0000_0110;
        end else if (c <= 3'd5) begin
          r.count = 4'd1; r.ch[0] = c;
        end
      end
      LM_51_STEREO, LM_71_STEREO: begin
        if (c == 3'd0 || c == 3'd1) begin
          r.count = 4'd1; r.ch[0] = c;
        end else if (c == 3'd2) begin
          r.count = 4'd2; r.ch[0] = 3'd0; r.ch[1] = 3'd1; r.gain = G_CENTRE;
        end else if (c == 3'd4 || c == 3'd5) begin
          r.count = 4'd1; r.ch[0] = {2'd0, c[0]}; r.gain = G_SURR;
        end else if ((c == 3'd6 || c == 3'd7) && layout_e'(lm) == LM_71_STEREO) begin
          r.count = 4'd1; r.ch[0] = {2'd0, c[0]}; r.gain = G_SURR;
        end
      end
      LM_Q_STEREO: begin
        if (c == 3'd0 || c == 3'd1) begin
          r.count = 4'd1; r.ch[0] = c; r.gain = G_QFRONT;
        end else if (c == 3'd2 || c == 3'd3) begin
          r.count = 4'd1; r.ch[0] = {2'd0, c[0]}; r.gain = G_QBACK;
        end
      end
      default: begin
        r.count = '0;
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pcm_decode_channel_remix_unit.sv
`timescale 1ns / 1ps

// channel  | direction | handshake                   | payload
// ---------+-----------+-----------------------------+-------------------------
// in       | input     | in_valid_i / in_stall_o     | in_data_i  (in_item_t)
// out      | output    | out_valid_o / out_stall_i   | out_data_o (out_item_t)
// config   | input     | apb psel/penable/pwrite     | paddr, pwdata, prdata
//
// an item is held in the input register, then decode, routing and the
// gain multiply load the write list; the list drains one write per cycle
// when not stalled; an item gives 1 to 8 writes (list length), unrouted none
// a new item is taken while the previous list is still draining
// reset: registers return to 16-bit, passthrough, overwrite; pipeline empty
// out_stall_i holds the current write and backs up into in_stall_o

module pcm_decode_channel_remix_unit #(
  parameter int unsigned OFFSET_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  pdcr_pkg::in_item_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output pdcr_pkg::out_item_t          out_data_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pdcr_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam logic [pdcr_pkg::OffW-1:0] OffMask =
    (OFFSET_BITS >= pdcr_pkg::OffW) ? {pdcr_pkg::OffW{1'b1}} :
    pdcr_pkg::OffW'((64'd1 << OFFSET_BITS) - 64'd1);

  logic [1:0] sample_width_q;
  logic [3:0] layout_mode_q;
  logic       write_mode_q;

  logic               in_vld_q;
  pdcr_pkg::in_item_t in_q;

  logic [pdcr_pkg::CntW-1:0]               rem_q, rem_d;
  logic [pdcr_pkg::MaxRes-1:0][2:0]        ch_q, ch_d;
  logic [pdcr_pkg::MaxRes-1:0]             mute_q, mute_d;
  logic signed [31:0]                      val_q, val_d;
  logic                                    acc_q, acc_d;
  logic [pdcr_pkg::OffW-1:0]               off_q, off_d;

  pdcr_pkg::reg_idx_e  reg_idx;
  logic                cfg_wr;
  pdcr_pkg::route_t    rt;
  logic signed [31:0]  norm;
  logic signed [16:0]  gain_s;
  logic signed [48:0]  prod;
  logic                out_take;
  logic                list_free;
  logic                move;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = pdcr_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    case (reg_idx)
      pdcr_pkg::REG_SAMPLE_WIDTH: prdata = {30'd0, sample_width_q};
      pdcr_pkg::REG_LAYOUT_MODE:  prdata = {28'd0, layout_mode_q};
      pdcr_pkg::REG_WRITE_MODE:   prdata = {31'd0, write_mode_q};
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_width_q <= 2'd1;
      layout_mode_q  <= 4'd0;
      write_mode_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        pdcr_pkg::REG_SAMPLE_WIDTH: sample_width_q <= pwdata[1:0];
        pdcr_pkg::REG_LAYOUT_MODE:  layout_mode_q  <= pwdata[3:0];
        pdcr_pkg::REG_WRITE_MODE:   write_mode_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_valid_o = (rem_q != '0);
  assign out_take    = out_valid_o & ~out_stall_i;
  assign list_free   = (rem_q == '0) | ((rem_q == pdcr_pkg::CntW'(1)) & ~out_stall_i);
  assign move        = in_vld_q & list_free;
  assign in_stall_o  = in_vld_q & ~list_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (~in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i & ~in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // decode, route, gain
  assign norm   = pdcr_pkg::normalize(sample_width_q, in_q.raw_sample);
  assign rt     = pdcr_pkg::route(layout_mode_q, in_q.source_channel);
  assign gain_s = signed'({1'b0, pdcr_pkg::gain_value(rt.gain)});
  assign prod   = norm * gain_s;

  always_comb begin
    rem_d  = rem_q;
    ch_d   = ch_q;
    mute_d = mute_q;
    val_d  = val_q;
    acc_d  = acc_q;
    off_d  = off_q;
    if (move) begin
      rem_d  = rt.count;
      ch_d   = rt.ch;
      mute_d = rt.mute;
      val_d  = signed'(prod[46:15]);
      acc_d  = write_mode_q;
      off_d  = in_q.frame_offset & OffMask;
    end else if (out_take) begin
      rem_d = rem_q - pdcr_pkg::CntW'(1);
      for (int i = 0; i < pdcr_pkg::MaxRes - 1; i++) begin
        ch_d[i]   = ch_q[i+1];
        mute_d[i] = mute_q[i+1];
      end
      ch_d[pdcr_pkg::MaxRes-1]   = '0;
      mute_d[pdcr_pkg::MaxRes-1] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    mute_q <= mute_d;
    val_q  <= val_d;
    acc_q  <= acc_d;
    off_q  <= off_d;
  end

  assign out_data_o.dest_channel = ch_q[0];
  assign out_data_o.sample_value = mute_q[0] ? 32'sd0 : val_q;
  assign out_data_o.accumulate   = acc_q;
  assign out_data_o.dest_offset  = off_q;
  assign out_data_o.last         = (rem_q == pdcr_pkg::CntW'(1));

endmodule
